// ----- hdl/tea_pkg.sv -----
`timescale 1ns / 1ps

package tea_pkg;

    localparam int WORD_W = 64;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
    localparam int          TEA_SHL   = 4;
    localparam int          TEA_SHR   = 5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int          CFG_IDX_W       = 3;
    localparam logic [2:0]  REG_ROUND_COUNT = 3'd0;
    localparam logic [2:0]  REG_KEY_PART0   = 3'd1;
    localparam logic [2:0]  REG_KEY_PART1   = 3'd2;
    localparam logic [2:0]  REG_KEY_PART2   = 3'd3;
    localparam logic [2:0]  REG_KEY_PART3   = 3'd4;

    localparam logic [6:0]  ROUND_COUNT_RESET = 7'd32;

    typedef struct packed {
        t_word k0;
        t_word k1;
        t_word k2;
        t_word k3;
    } t_key;

    // one word in flight through the round chain
    typedef struct packed {
        logic  valid;
        logic  op;
        t_word y;
        t_word z;
    } t_stage;

    function automatic t_word tea_mix(t_word w, t_word s, t_word ka, t_word kb);
        return ((w << TEA_SHL) + ka) ^ (w + s) ^ ((w >> TEA_SHR) + kb);
    endfunction

endpackage

// ----- hdl/tea_cell.sv -----
`timescale 1ns / 1ps

module tea_cell #(
    parameter int ROUND  = 0,
    parameter bit SECOND = 1'b0,
    parameter int RW     = 7,
    parameter int SW     = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [RW-1:0]    i_rounds,
    input  tea_pkg::t_key    i_key,
    input  tea_pkg::t_stage  i_stage,
    input  logic [SW-1:0]    i_sum,
    output tea_pkg::t_stage  o_stage,
    output logic [SW-1:0]    o_sum
);
    import tea_pkg::*;

    logic   w_active;
    logic   w_enc;
    logic   w_tgt_y;
    t_word  w_src;
    t_word  w_tgt;
    t_word  w_ka;
    t_word  w_kb;
    t_word  w_mix;
    t_word  w_res;

    t_stage        r_stage;
    t_stage        n_stage;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] n_sum;

    assign w_active = (RW'(ROUND) < i_rounds);
    assign w_enc    = (i_stage.op == OP_ENCRYPT);

    // encrypt: y then z; decrypt: z then y
    assign w_tgt_y = SECOND ? !w_enc : w_enc;
    assign w_src   = w_tgt_y ? i_stage.z : i_stage.y;
    assign w_tgt   = w_tgt_y ? i_stage.y : i_stage.z;
    assign w_ka    = w_tgt_y ? i_key.k0 : i_key.k2;
    assign w_kb    = w_tgt_y ? i_key.k1 : i_key.k3;
    assign w_mix   = tea_mix(w_src, WORD_W'(i_sum), w_ka, w_kb);
    assign w_res   = w_enc ? (w_tgt + w_mix) : (w_tgt - w_mix);

    always_comb begin
        n_stage = i_stage;
        n_sum   = i_sum;
        if (w_active) begin
            if (w_tgt_y) begin
                n_stage.y = w_res;
            end else begin
                n_stage.z = w_res;
            end
            // sum steps once per round, after the second half
            if (SECOND) begin
                n_sum = w_enc ? (i_sum + SW'(TEA_DELTA)) : (i_sum - SW'(TEA_DELTA));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.op <= n_stage.op;
            r_stage.y  <= n_stage.y;
            r_stage.z  <= n_stage.z;
            r_sum      <= n_sum;
        end
    end

    assign o_stage = r_stage;
    assign o_sum   = r_sum;

endmodule

// ----- hdl/tea_block_cipher_64bit_words.sv -----
`timescale 1ns / 1ps
// The input register loads on the accepting edge, then two half-round cells per round
// follow for each of the MAX_ROUNDS rounds; the last cell register drives o_valid.
// Throughput: one word per cycle; the whole chain advances unless the output waits.
// Rounds below MAX_ROUNDS pass through the idle cells unchanged.
// Reset (i_rst_n low, synchronous): clears all valid flags, round_count to 32, keys to 0.
module tea_block_cipher_64bit_words #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  tea_pkg::t_word                i_left_word,
    input  tea_pkg::t_word                i_right_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tea_pkg::t_word                o_left_result,
    output tea_pkg::t_word                o_right_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tea_pkg::t_word                i_cfg_data
);
    import tea_pkg::*;

    localparam int RW     = $clog2(MAX_ROUNDS + 1);
    localparam int SW     = 32 + $clog2(MAX_ROUNDS + 2);
    localparam int NCELLS = 2 * MAX_ROUNDS;

    logic [6:0]    r_round_count;
    t_key          r_key;
    logic [RW-1:0] w_rounds;
    logic          w_en;

    t_stage        r_in;
    logic [SW-1:0] r_in_sum;
    logic [SW-1:0] n_in_sum;

    t_stage        w_stage [0:NCELLS];
    logic [SW-1:0] w_sum   [0:NCELLS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= ROUND_COUNT_RESET;
            r_key         <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROUND_COUNT: r_round_count <= i_cfg_data[6:0];
                REG_KEY_PART0:   r_key.k0      <= i_cfg_data;
                REG_KEY_PART1:   r_key.k1      <= i_cfg_data;
                REG_KEY_PART2:   r_key.k2      <= i_cfg_data;
                REG_KEY_PART3:   r_key.k3      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_round_count == 7'd0) begin
            w_rounds = RW'(1);
        end else if (int'(r_round_count) > MAX_ROUNDS) begin
            w_rounds = RW'(MAX_ROUNDS);
        end else begin
            w_rounds = RW'(r_round_count);
        end
    end

    // single pipeline enable; last cell register is the output register
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // decrypt starts at rounds*delta, encrypt at delta (sum is stepped after each round)
    assign n_in_sum = (i_operation == OP_ENCRYPT) ? SW'(TEA_DELTA)
                                                  : SW'(w_rounds) * SW'(TEA_DELTA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= i_valid;
        end
        if (w_en) begin
            r_in.op  <= i_operation;
            r_in.y   <= i_left_word;
            r_in.z   <= i_right_word;
            r_in_sum <= n_in_sum;
        end
    end

    assign w_stage[0] = r_in;
    assign w_sum[0]   = r_in_sum;

    for (genvar c = 0; c < NCELLS; c++) begin : g_cell
        tea_cell #(
            .ROUND  (c / 2),
            .SECOND (bit'(c % 2)),
            .RW     (RW),
            .SW     (SW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_rounds (w_rounds),
            .i_key    (r_key),
            .i_stage  (w_stage[c]),
            .i_sum    (w_sum[c]),
            .o_stage  (w_stage[c+1]),
            .o_sum    (w_sum[c+1])
        );
    end

    assign o_valid        = w_stage[NCELLS].valid;
    assign o_left_result  = w_stage[NCELLS].y;
    assign o_right_result = w_stage[NCELLS].z;

`ifndef SYNTHESIS
    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result waiting");

    a_rounds_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rounds >= RW'(1)) && (int'(w_rounds) <= MAX_ROUNDS))
        else $error("effective round count out of range");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in.valid)
        else $error("accepted word lost at chain entry");
`endif

endmodule

// ----- verif/tea_block_cipher_64bit_words_tb.sv -----
`timescale 1ns / 1ps

module tea_block_cipher_64bit_words_tb;

    import tea_pkg::*;

    localparam int MAX_ROUNDS     = 64;
    localparam int PIPE_LATENCY   = 2 * MAX_ROUNDS + 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BLOCKS   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_KEY_PART3 + 1'b1;

    typedef struct packed {
        logic  op;
        t_word left_in;
        t_word right_in;
    } t_block;

    typedef struct packed {
        t_word left_half;
        t_word right_half;
    } t_halves;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic                 i_operation  = OP_ENCRYPT;
    t_word                i_left_word  = '0;
    t_word                i_right_word = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    t_word                o_left_result;
    t_word                o_right_result;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = REG_ROUND_COUNT;
    t_word                i_cfg_data   = '0;

    // shadow of the block's registers
    logic [6:0] round_cfg = ROUND_COUNT_RESET;
    t_key       key_cfg   = '0;

    t_block  block_in_q[$];
    t_halves block_out_q[$];
    t_halves cipher_head;

    int   blocks_queued   = 0;
    int   blocks_accepted = 0;
    int   mismatch_count  = 0;
    int   quiet_cycles    = 0;
    int   send_gap        = 0;
    int   stall_left      = 0;
    logic in_taken        = 1'b0;
    logic idle_on         = 1'b1;

    tea_block_cipher_64bit_words #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_left_word   (i_left_word),
        .i_right_word  (i_right_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_result (o_left_result),
        .o_right_result(o_right_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_word round_mix(t_word w, t_word s, t_word ka, t_word kb);
        return ((w << TEA_SHL) + ka) ^ (w + s) ^ ((w >> TEA_SHR) + kb);
    endfunction

    function automatic t_halves tea_transform(logic op, t_word y_in, t_word z_in);
        t_word   y;
        t_word   z;
        t_word   sum;
        t_word   delta;
        int      rounds;
        int      i;
        t_halves res;
        y      = y_in;
        z      = z_in;
        delta  = t_word'(TEA_DELTA);
        rounds = (round_cfg == 7'd0) ? 1
               : (int'(round_cfg) > MAX_ROUNDS) ? MAX_ROUNDS : int'(round_cfg);
        if (op == OP_ENCRYPT) begin
            sum = '0;
            for (i = 0; i < rounds; i++) begin
                sum += delta;
                y   += round_mix(z, sum, key_cfg.k0, key_cfg.k1);
                z   += round_mix(y, sum, key_cfg.k2, key_cfg.k3);
            end
        end else begin
            sum = delta * t_word'(rounds);
            for (i = 0; i < rounds; i++) begin
                z   -= round_mix(y, sum, key_cfg.k2, key_cfg.k3);
                y   -= round_mix(z, sum, key_cfg.k0, key_cfg.k1);
                sum -= delta;
            end
        end
        res.left_half  = y;
        res.right_half = z;
        return res;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic log_mismatch(string msg);
        if (mismatch_count < 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic queue_block(logic op, t_word l, t_word r);
        block_in_q.push_back('{op: op, left_in: l, right_in: r});
        blocks_queued++;
    endtask

    // sender pauses here until every queued word has come back out
    task automatic drain();
        do @(negedge i_clk);
        while (blocks_accepted != blocks_queued || block_out_q.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, t_word data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic load_config(t_word rc_data, t_key k);
        cfg_write(REG_ROUND_COUNT, rc_data);
        cfg_write(REG_KEY_PART0, k.k0);
        cfg_write(REG_KEY_PART1, k.k1);
        cfg_write(REG_KEY_PART2, k.k2);
        cfg_write(REG_KEY_PART3, k.k3);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (block_in_q.size() != 0 && idle_on && $urandom_range(7) == 0) begin
                send_gap <= $urandom_range(13);
                i_valid  <= 1'b0;
            end else if (block_in_q.size() != 0) begin
                {i_operation, i_left_word, i_right_word} <= block_in_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (idle_on && $urandom_range(7) == 0) begin
            stall_left <= $urandom_range(13);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROUND_COUNT: round_cfg  = i_cfg_data[6:0];
                    REG_KEY_PART0:   key_cfg.k0 = i_cfg_data;
                    REG_KEY_PART1:   key_cfg.k1 = i_cfg_data;
                    REG_KEY_PART2:   key_cfg.k2 = i_cfg_data;
                    REG_KEY_PART3:   key_cfg.k3 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                block_out_q.push_back(tea_transform(i_operation, i_left_word, i_right_word));
                blocks_accepted++;
            end
            if (o_valid && !i_stall) begin
                if (block_out_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected word left %h right %h",
                                           o_left_result, o_right_result));
                end else begin
                    cipher_head = block_out_q.pop_front();
                    if (o_left_result !== cipher_head.left_half ||
                        o_right_result !== cipher_head.right_half) begin
                        log_mismatch($sformatf("left exp %h got %h, right exp %h got %h",
                                               cipher_head.left_half, o_left_result,
                                               cipher_head.right_half, o_right_result));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tea_block_cipher_64bit_words regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_word   rc_data;
        t_key    k;
        t_halves res;
        logic    op;
        int      phase;
        int      idx;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset settings: 32 rounds, zero key
        queue_block(OP_ENCRYPT, '0, '0);
        queue_block(OP_ENCRYPT, '1, '1);
        queue_block(OP_DECRYPT, '0, '0);
        queue_block(OP_DECRYPT, '1, '1);
        queue_block(OP_ENCRYPT, t_word'(1) << (WORD_W - 1), t_word'(1));
        queue_block(OP_DECRYPT, t_word'(1), t_word'(1) << (WORD_W - 1));
        drain();

        // zero rounds runs as one, all-ones key
        load_config('0, '1);
        queue_block(OP_ENCRYPT, '1, '0);
        queue_block(OP_DECRYPT, '0, '1);
        drain();

        // count above the cap, exactly at the cap, one past it
        k = {rand_word(), rand_word(), rand_word(), rand_word()};
        load_config(t_word'(7'h7f), k);
        queue_block(OP_ENCRYPT, '1, '1);
        queue_block(OP_DECRYPT, '1, '0);
        drain();
        load_config(t_word'(MAX_ROUNDS), '0);
        queue_block(OP_ENCRYPT, '0, '1);
        queue_block(OP_DECRYPT, '1, '1);
        drain();
        load_config(t_word'(MAX_ROUNDS + 1), k);
        queue_block(OP_ENCRYPT, rand_word(), rand_word());
        queue_block(OP_DECRYPT, rand_word(), rand_word());
        drain();

        // upper data bits dropped on the round register; unused indexes ignored
        k = {rand_word(), rand_word(), rand_word(), rand_word()};
        load_config(64'hffff_ffff_ffff_ff85, k);
        for (idx = REG_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++) begin
            cfg_write(idx[CFG_IDX_W-1:0], '1);
        end
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        queue_block(OP_ENCRYPT, rand_word(), rand_word());
        queue_block(OP_DECRYPT, rand_word(), rand_word());
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = (phase != 3 && phase != RANDOM_PHASES - 1);
            rc_data = {$urandom, $urandom};
            case (phase)
                0:       rc_data[6:0] = 7'd1;
                1:       rc_data[6:0] = 7'(MAX_ROUNDS);
                default: rc_data[6:0] = ($urandom_range(3) == 0)
                                      ? 7'($urandom_range(7'h7f))
                                      : 7'($urandom_range(MAX_ROUNDS, 1));
            endcase
            k = {rand_word(), rand_word(), rand_word(), rand_word()};
            load_config(rc_data, k);
            idx = blocks_queued + PHASE_BLOCKS;
            while (blocks_queued < idx) begin
                op = 1'($urandom_range(1));
                queue_block(op, rand_word(), rand_word());
                // round trip: feed the transformed word back through the inverse op
                if ($urandom_range(3) == 0) begin
                    res = tea_transform(block_in_q[$].op, block_in_q[$].left_in,
                                        block_in_q[$].right_in);
                    queue_block(~op, res.left_half, res.right_half);
                end
            end
            drain();
        end

        repeat (PIPE_LATENCY + 16) @(posedge i_clk);
        if (block_out_q.size() != 0) begin
            log_mismatch($sformatf("%0d words never came out", block_out_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("tea_block_cipher_64bit_words regression: pass");
        end else begin
            $display("tea_block_cipher_64bit_words regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tea_pkg.sv
hdl/tea_cell.sv
hdl/tea_block_cipher_64bit_words.sv
verif/tea_block_cipher_64bit_words_tb.sv
